/* rtl/core/ssr_pkg.sv */
// Shared constants, types and state codes for the 4x4 supersample resolve.
// No dependencies; imported by every module of the block.
package ssr_pkg;

  // Line store depth and derived widths
  localparam int MaxOutWidth = 1024;
  localparam int CfgWidthW   = 11;
  localparam int HeightW     = 16;
  localparam int ClogMax     = $clog2(MaxOutWidth + 1);
  localparam int EffWidthW   = (CfgWidthW > ClogMax) ? CfgWidthW : ClogMax;
  localparam int ColW        = EffWidthW + 2;
  localparam int OcolW       = (MaxOutWidth > 1) ? $clog2(MaxOutWidth) : 1;

  // Sum widths
  localparam int SumW     = 20;
  localparam int AlphaW   = 12;
  localparam int ChanW    = 8;
  localparam int EntryW   = 3 * SumW + AlphaW;

  // Register indexes
  localparam logic RegOutWidth  = 1'b0;
  localparam logic RegOutHeight = 1'b1;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_UPD,
    CTL_RMS,
    CTL_HOLD
  } ctl_state_e;

  typedef enum logic [1:0] {
    RMS_IDLE,
    RMS_SRCH,
    RMS_TIE
  } rms_state_e;

  // Request to the root unit
  typedef struct packed {
    logic                       start;
    logic [2:0][SumW-1:0]       sums;
  } rms_req_t;

endpackage

/* rtl/core/ssr_lstore.sv */
// Line store: per-output-column partial sums, one synchronous RAM port each
// for read and write. Depends on ssr_pkg.
module ssr_lstore (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic [ssr_pkg::OcolW-1:0]    rd_addr_i,
  output logic [ssr_pkg::EntryW-1:0]   rd_data_o,
  input  logic                         wr_en_i,
  input  logic [ssr_pkg::OcolW-1:0]    wr_addr_i,
  input  logic [ssr_pkg::EntryW-1:0]   wr_data_i
);
  import ssr_pkg::*;

  logic [EntryW-1:0] mem [MaxOutWidth];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

/* rtl/core/ssr_rms.sv */
// Iterative root unit: nearest integer to sqrt(s/16), ties to even, for three
// channels, one result bit per cycle. Depends on ssr_pkg.
module ssr_rms (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ssr_pkg::rms_req_t                  req_i,
  output logic                               done_o,
  output logic [2:0][ssr_pkg::ChanW-1:0]     root_o
);
  import ssr_pkg::*;

  rms_state_e state_q, state_d;
  logic [2:0]                 step_q, step_d;
  logic [2:0][SumW-1:0]       s_q, s_d;
  logic [2:0][ChanW-1:0]      n_q, n_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      RMS_IDLE: if (req_i.start) state_d = RMS_SRCH;
      RMS_SRCH: if (step_q == 3'd0) state_d = RMS_TIE;
      RMS_TIE:  state_d = RMS_IDLE;
      default:  state_d = RMS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done_o = (state_q == RMS_TIE);
    root_o = n_q;
  end

  // datapath: binary search on the rounding edges (4n+2)^2
  always_comb begin
    logic [ChanW-1:0]   t;
    logic [ChanW-1:0]   tm1;
    logic [ChanW+1:0]   e;
    logic [SumW-1:0]    e2;
    step_d = step_q;
    s_d    = s_q;
    n_d    = n_q;
    t      = '0;
    tm1    = '0;
    e      = '0;
    e2     = '0;
    case (state_q)
      RMS_IDLE: begin
        if (req_i.start) begin
          s_d    = req_i.sums;
          n_d    = '0;
          step_d = 3'd7;
        end
      end
      RMS_SRCH: begin
        step_d = step_q - 3'd1;
        for (int c = 0; c < 3; c++) begin
          t   = n_q[c] | (ChanW'(1) << step_q);
          tm1 = t - ChanW'(1);
          e   = {tm1, 2'b10};
          e2  = SumW'(e * e);
          if (e2 < s_q[c]) n_d[c] = t;
        end
      end
      RMS_TIE: begin
        // exact tie at an odd root rounds up to the even neighbor
        for (int c = 0; c < 3; c++) begin
          e  = {n_q[c], 2'b10};
          e2 = SumW'(e * e);
          if ((e2 == s_q[c]) && n_q[c][0] && (n_q[c] != '1)) begin
            n_d[c] = n_q[c] + ChanW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RMS_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
    n_q <= n_d;
  end

endmodule

/* rtl/core/supersample_resolve_4x4_rms.sv */
// Top level of the 4x4 RMS supersample resolve: control, registers, output.
// Depends on ssr_pkg, ssr_lstore and ssr_rms.
//
//  channel   | signals                                  | direction
//  ----------+------------------------------------------+----------
//  pixel     | pixel_valid_i, pixel_ready_o, pixel_i    | in
//  resolved  | resolved_valid_o, resolved_ready_i,      | out
//            | resolved_pixel_o, row_end_o, frame_end_o |
//  config    | psel, penable, pwrite, paddr, pwdata,    | in/out
//            | prdata, pready                           |
//
// A pixel that ends no block passes through a line store read, then update and
// write back. The block's last pixel then waits for the bit-serial root (8
// search steps and a tie step) and for the output register to be free before
// it loads. Reset clears counters and control; the line store needs no pass.
// The output register lets the next pixel in while a result waits.
module supersample_resolve_4x4_rms (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pixel_valid_i,
  output logic        pixel_ready_o,
  input  logic [31:0] pixel_i,
  output logic        resolved_valid_o,
  input  logic        resolved_ready_i,
  output logic [31:0] resolved_pixel_o,
  output logic        row_end_o,
  output logic        frame_end_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ssr_pkg::*;

  ctl_state_e state_q, state_d;

  logic [CfgWidthW-1:0] out_width_q;
  logic [HeightW-1:0]   out_height_q;
  logic [ColW-1:0]      col_q, col_d;
  logic [1:0]           phase_q, phase_d;
  logic [HeightW-1:0]   orow_q, orow_d;

  logic [31:0]          pix_q;
  logic [ChanW-1:0]     alpha_q, alpha_d;
  logic                 rend_q, rend_d, fend_q, fend_d;

  logic                 out_valid_q, out_valid_d;
  logic [31:0]          out_pix_q;
  logic                 out_rend_q, out_fend_q;

  logic                 accept, load_out;
  logic [EffWidthW-1:0] eff_w;
  logic [HeightW-1:0]   eff_h;
  logic [OcolW-1:0]     ocol;
  logic [EntryW-1:0]    rd_data, wr_data;
  logic                 wr_en;
  rms_req_t             rms_req;
  logic                 rms_done;
  logic [2:0][ChanW-1:0] roots;

  // configuration port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      RegOutWidth:  prdata = 32'(out_width_q);
      RegOutHeight: prdata = 32'(out_height_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_width_q  <= CfgWidthW'(1);
      out_height_q <= HeightW'(1);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == RegOutWidth) out_width_q <= pwdata[CfgWidthW-1:0];
      else                         out_height_q <= pwdata[HeightW-1:0];
    end
  end

  // effective geometry
  always_comb begin
    logic [EffWidthW-1:0] wx;
    wx = EffWidthW'(out_width_q);
    if (wx == '0) eff_w = EffWidthW'(1);
    else if (int'(wx) > MaxOutWidth) eff_w = EffWidthW'(MaxOutWidth);
    else eff_w = wx;
    eff_h = (out_height_q == '0) ? HeightW'(1) : out_height_q;
  end

  // output column, clamped to the line store depth
  always_comb begin
    logic [ColW-3:0] oc;
    oc = col_q[ColW-1:2];
    if (int'(oc) > MaxOutWidth - 1) ocol = OcolW'(MaxOutWidth - 1);
    else ocol = OcolW'(oc);
  end

  assign accept = pixel_valid_i && pixel_ready_o;

  ssr_lstore u_lstore (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (ocol),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (ocol),
    .wr_data_i (wr_data)
  );

  ssr_rms u_rms (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rms_req),
    .done_o (rms_done),
    .root_o (roots)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CTL_IDLE: if (accept) state_d = CTL_UPD;
      CTL_UPD:  if ((phase_q == 2'd3) && (col_q[1:0] == 2'd3)) state_d = CTL_RMS;
                else state_d = CTL_IDLE;
      CTL_RMS:  if (rms_done) state_d = CTL_HOLD;
      CTL_HOLD: if (!out_valid_q || resolved_ready_i) state_d = CTL_IDLE;
      default:  state_d = CTL_IDLE;
    endcase
  end

  // outputs of the control FSM
  always_comb begin
    pixel_ready_o = (state_q == CTL_IDLE);
    wr_en         = (state_q == CTL_UPD);
    load_out      = (state_q == CTL_HOLD) && (!out_valid_q || resolved_ready_i);
  end

  // accumulate one pixel into the column's partial sums
  always_comb begin
    logic [EntryW-1:0]  base;
    logic [2:0][SumW-1:0] sums;
    logic [AlphaW-1:0]  al;
    logic [7:0]         px;
    logic [ChanW:0]     q;
    base = rd_data;
    if ((phase_q == 2'd0) && (col_q[1:0] == 2'd0)) base = '0;
    for (int c = 0; c < 3; c++) begin
      px      = pix_q[8*c +: 8];
      sums[c] = base[SumW*c +: SumW] + SumW'(px * px);
    end
    al = base[3*SumW +: AlphaW] + AlphaW'(pix_q[31:24]);
    wr_data = {al, sums[2], sums[1], sums[0]};

    rms_req.start = wr_en && (phase_q == 2'd3) && (col_q[1:0] == 2'd3);
    rms_req.sums  = sums;

    // alpha mean, ties to even
    q = {1'b0, al[AlphaW-1:4]};
    if ((al[3:0] > 4'd8) || ((al[3:0] == 4'd8) && q[0])) q = q + (ChanW+1)'(1);
    alpha_d = q[ChanW] ? '1 : q[ChanW-1:0];
    if (!wr_en) alpha_d = alpha_q;

    rend_d = rend_q;
    fend_d = fend_q;
    if (wr_en) begin
      rend_d = (EffWidthW'(ocol) == eff_w - EffWidthW'(1));
      fend_d = rend_d && (orow_q == eff_h - HeightW'(1));
    end
  end

  // position counters advance after each pixel's update
  always_comb begin
    logic [ColW:0] cnext;
    col_d   = col_q;
    phase_d = phase_q;
    orow_d  = orow_q;
    cnext   = {1'b0, col_q} + (ColW+1)'(1);
    if (wr_en) begin
      if (cnext >= (ColW+1)'({eff_w, 2'b00})) begin
        col_d = '0;
        if (phase_q == 2'd3) begin
          phase_d = 2'd0;
          if (({1'b0, orow_q} + (HeightW+1)'(1)) >= (HeightW+1)'(eff_h)) orow_d = '0;
          else orow_d = orow_q + HeightW'(1);
        end else begin
          phase_d = phase_q + 2'd1;
        end
      end else begin
        col_d = cnext[ColW-1:0];
      end
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (resolved_valid_o && resolved_ready_i) out_valid_d = 1'b0;
    if (load_out) out_valid_d = 1'b1;
  end

  assign resolved_valid_o = out_valid_q;
  assign resolved_pixel_o = out_pix_q;
  assign row_end_o        = out_rend_q;
  assign frame_end_o      = out_fend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTL_IDLE;
      col_q       <= '0;
      phase_q     <= '0;
      orow_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      phase_q     <= phase_d;
      orow_q      <= orow_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) pix_q <= pixel_i;
    alpha_q <= alpha_d;
    rend_q  <= rend_d;
    fend_q  <= fend_d;
    if (load_out) begin
      out_pix_q  <= {alpha_q, roots[2], roots[1], roots[0]};
      out_rend_q <= rend_q;
      out_fend_q <= fend_q;
    end
  end

endmodule
